// ----- rtl/core/e2q_pkg.sv -----
package e2q_pkg;

  localparam int AngW = 18;
  localparam int QW = 16;
  // CORDIC datapath: 30 fraction bits, values stay well below 2^32.
  localparam int CW = 34;
  localparam int TabLen = 24;
  localparam logic signed [CW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [CW-1:0] PiQ30 = 34'sd3373259426;
  localparam logic signed [CW-1:0] HalfPiQ30 = 34'sd1686629713;
  // Cosine and sine after rounding: 20 fraction bits, magnitude up to about 1.
  localparam int TW = 23;

  typedef struct packed {
    logic signed [AngW-1:0] roll;
    logic signed [AngW-1:0] pitch;
    logic signed [AngW-1:0] yaw;
  } angles_t;

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } quat_t;

  function automatic logic signed [CW-1:0] atan_entry(input int i);
    logic signed [CW-1:0] t;
    case (i)
      0: t = 34'sh03243F6A8;
      1: t = 34'sh01DAC6705;
      2: t = 34'sh00FADBAFC;
      3: t = 34'sh007F56EA6;
      4: t = 34'sh003FEAB76;
      5: t = 34'sh001FFD55B;
      6: t = 34'sh000FFFAAA;
      7: t = 34'sh0007FFF55;
      8: t = 34'sh0003FFFEA;
      9: t = 34'sh0001FFFFD;
      10: t = 34'sh0000FFFFF;
      11: t = 34'sh00007FFFF;
      12: t = 34'sh00003FFFF;
      13: t = 34'sh00001FFFF;
      14: t = 34'sh00000FFFF;
      15: t = 34'sh000007FFF;
      16: t = 34'sh000003FFF;
      17: t = 34'sh000001FFF;
      18: t = 34'sh000000FFF;
      19: t = 34'sh0000007FF;
      20: t = 34'sh0000003FF;
      21: t = 34'sh0000001FF;
      22: t = 34'sh0000000FF;
      default: t = 34'sh00000007F;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/core/e2q_front.sv -----
module e2q_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  e2q_pkg::angles_t  in_ang,
  output logic              in_ready,
  output logic              out_valid,
  output e2q_pkg::angles_t  out_ang,
  input  logic              out_ready
);
  import e2q_pkg::*;

  // Two-entry queue between the input side and the CORDIC pipeline.
  angles_t   mem_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  logic      push, pop;

  assign in_ready  = cnt_r != 2'd2;
  assign out_valid = cnt_r != 2'd0;
  assign out_ang   = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_ang;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- rtl/core/e2q_back.sv -----
module e2q_back #(
  parameter int Iter = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  e2q_pkg::angles_t  in_ang,
  output logic              out_valid,
  output e2q_pkg::quat_t    out_q
);
  import e2q_pkg::*;

  localparam int N = (Iter > TabLen) ? TabLen : Iter;
  localparam int PW = 2 * TW;
  localparam int FW = 3 * TW;
  // Stages: fold, N CORDIC steps, round, 2 product, sum, saturate.
  localparam int Depth = N + 6;

  logic signed [CW-1:0] x_r [3][N+1];
  logic signed [CW-1:0] y_r [3][N+1];
  logic signed [CW-1:0] z_r [3][N+1];
  logic                 ng_r [3][N+1];
  logic [Depth-1:0]     v_r;

  logic signed [TW-1:0] c_r [3];
  logic signed [TW-1:0] s_r [3];
  logic signed [PW-1:0] p_r [8];
  logic signed [TW-1:0] t_r [8];
  logic signed [FW:0]   f_r [4];
  quat_t                q_r;

  always_comb begin
    out_valid = v_r[Depth-1];
    out_q = q_r;
  end

  for (genvar a = 0; a < 3; a++) begin : g_ax
    logic signed [AngW-1:0] raw;
    logic signed [CW-1:0] z0;
    assign raw = (a == 0) ? in_ang.roll : (a == 1) ? in_ang.pitch : in_ang.yaw;
    assign z0 = CW'(raw) <<< 14;

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[a][0] <= CordicGain;
        y_r[a][0] <= '0;
        if (z0 > HalfPiQ30) begin
          z_r[a][0] <= z0 - PiQ30; ng_r[a][0] <= 1'b1;
        end else if (z0 < -HalfPiQ30) begin
          z_r[a][0] <= z0 + PiQ30; ng_r[a][0] <= 1'b1;
        end else begin
          z_r[a][0] <= z0; ng_r[a][0] <= 1'b0;
        end
      end
    end

    for (genvar i = 0; i < N; i++) begin : g_it
      always_ff @(posedge clk) begin
        if (adv) begin
          ng_r[a][i+1] <= ng_r[a][i];
          if (!z_r[a][i][CW-1]) begin
            x_r[a][i+1] <= x_r[a][i] - (y_r[a][i] >>> i);
            y_r[a][i+1] <= y_r[a][i] + (x_r[a][i] >>> i);
            z_r[a][i+1] <= z_r[a][i] - atan_entry(i);
          end else begin
            x_r[a][i+1] <= x_r[a][i] + (y_r[a][i] >>> i);
            y_r[a][i+1] <= y_r[a][i] - (x_r[a][i] >>> i);
            z_r[a][i+1] <= z_r[a][i] + atan_entry(i);
          end
        end
      end
    end

    logic signed [CW-1:0] xr, yr;
    assign xr = (x_r[a][N] + CW'(512)) >>> 10;
    assign yr = (y_r[a][N] + CW'(512)) >>> 10;
    always_ff @(posedge clk) begin
      if (adv) begin
        c_r[a] <= ng_r[a][N] ? -TW'(xr) : TW'(xr);
        s_r[a] <= ng_r[a][N] ? -TW'(yr) : TW'(yr);
      end
    end
  end

  // Terms: index 0 roll, 1 pitch, 2 yaw.
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0] <= c_r[2] * c_r[0]; t_r[0] <= c_r[1];
      p_r[1] <= s_r[2] * s_r[0]; t_r[1] <= s_r[1];
      p_r[2] <= c_r[2] * s_r[0]; t_r[2] <= c_r[1];
      p_r[3] <= s_r[2] * c_r[0]; t_r[3] <= s_r[1];
      p_r[4] <= c_r[2] * c_r[0]; t_r[4] <= s_r[1];
      p_r[5] <= s_r[2] * s_r[0]; t_r[5] <= c_r[1];
      p_r[6] <= s_r[2] * c_r[0]; t_r[6] <= c_r[1];
      p_r[7] <= c_r[2] * s_r[0]; t_r[7] <= s_r[1];
    end
  end

  logic signed [FW-1:0] g_r [8];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 8; k++) g_r[k] <= FW'(p_r[k]) * FW'(t_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r[0] <= (FW+1)'(g_r[0]) + (FW+1)'(g_r[1]);
      f_r[1] <= (FW+1)'(g_r[2]) - (FW+1)'(g_r[3]);
      f_r[2] <= (FW+1)'(g_r[4]) + (FW+1)'(g_r[5]);
      f_r[3] <= (FW+1)'(g_r[6]) - (FW+1)'(g_r[7]);
    end
  end

  function automatic logic signed [QW-1:0] sat(input logic signed [FW:0] v);
    logic signed [FW:0] r;
    r = (v + ((FW+1)'(1) <<< 44)) >>> 45;
    if (r > 32767) return 16'sh7FFF;
    if (r < -32768) return 16'sh8000;
    return r[QW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r.w <= sat(f_r[0]);
      q_r.x <= sat(f_r[1]);
      q_r.y <= sat(f_r[2]);
      q_r.z <= sat(f_r[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[Depth-2:0], in_valid};
    end
  end
endmodule

// ----- rtl/core/euler_to_quaternion_unit.sv -----
// Euler angle (yaw, pitch, roll) to unit quaternion converter.
// An accepted request passes through the input queue, the pipeline and the result queue
// before its result shows on the output ports; the CORDIC is fully pipelined.
// Throughput: one request per clock while the result queue is not full or is popped.
// Reset: synchronous active-low rst_n empties both queues and the pipeline.
// Payload registers are not reset.
module euler_to_quaternion_unit #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [17:0] in_roll_angle,
  input  logic signed [17:0] in_pitch_angle,
  input  logic signed [17:0] in_yaw_angle,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [15:0] out_quat_w,
  output logic signed [15:0] out_quat_x,
  output logic signed [15:0] out_quat_y,
  output logic signed [15:0] out_quat_z
);
  import e2q_pkg::*;

  // The output queue takes the item leaving the pipeline whenever the pipeline advances.
  localparam int OQ = 4;

  angles_t in_ang, fq_ang;
  logic    in_rdy, fq_valid, fq_ready;
  logic    adv, bk_valid;
  quat_t   bk_q;

  assign in_ang = '{roll: in_roll_angle, pitch: in_pitch_angle, yaw: in_yaw_angle};
  assign in_full = ~in_rdy;

  // Front: accepts requests into a short queue.
  e2q_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_push), .in_ang(in_ang), .in_ready(in_rdy),
    .out_valid(fq_valid), .out_ang(fq_ang), .out_ready(fq_ready)
  );

  // Result queue. The pipeline advances as a whole whenever the queue has room
  // for the item leaving it, so a stalled consumer freezes the pipeline.
  quat_t       oq_r [OQ];
  logic [1:0]  owp_r, orp_r;
  logic [2:0]  ocnt_r;
  logic        opush, opop;

  assign opop  = out_pop && !out_empty;
  assign adv   = (ocnt_r < 3'(OQ)) || opop;
  assign fq_ready = adv;
  assign opush = adv && bk_valid;

  e2q_back #(.Iter(CORDIC_ITERATIONS)) u_back (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(fq_valid), .in_ang(fq_ang),
    .out_valid(bk_valid), .out_q(bk_q)
  );

  // The back pipeline's last stage is shown as out_valid before adv, so it is
  // pushed into the queue on the cycle it leaves the pipeline.
  always_ff @(posedge clk) begin
    if (opush) begin
      oq_r[owp_r] <= bk_q;
    end
    if (!rst_n) begin
      owp_r <= '0;
      orp_r <= '0;
      ocnt_r <= '0;
    end else begin
      if (opush) owp_r <= owp_r + 2'd1;
      if (opop) orp_r <= orp_r + 2'd1;
      ocnt_r <= ocnt_r + {2'b0, opush} - {2'b0, opop};
    end
  end

  assign out_empty  = ocnt_r == 3'd0;
  assign out_quat_w = oq_r[orp_r].w;
  assign out_quat_x = oq_r[orp_r].x;
  assign out_quat_y = oq_r[orp_r].y;
  assign out_quat_z = oq_r[orp_r].z;

  // The result queue never overflows.
  assert property (@(posedge clk) disable iff (!rst_n) ocnt_r <= 3'(OQ))
    else $error("result queue overflow");
  // A pop never happens from an empty queue count.
  assert property (@(posedge clk) disable iff (!rst_n) opop |-> ocnt_r != 3'd0)
    else $error("pop from empty result queue");
  // With a full result queue and no pop the pipeline is frozen.
  assert property (@(posedge clk) disable iff (!rst_n)
    (ocnt_r == 3'(OQ) && !opop) |-> !adv)
    else $error("pipeline advanced into full result queue");
  // A push into the result queue only when the pipeline tail holds an item.
  assert property (@(posedge clk) disable iff (!rst_n) opush |-> bk_valid)
    else $error("result pushed without valid item");
endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import e2q_pkg::*;

  localparam int Iters = 16;
  localparam int NumRandom = 1600;
  localparam int Latency = Iters + 8;
  localparam longint CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [17:0] in_roll_angle = '0;
  logic signed [17:0] in_pitch_angle = '0;
  logic signed [17:0] in_yaw_angle = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [15:0] out_quat_w;
  logic signed [15:0] out_quat_x;
  logic signed [15:0] out_quat_y;
  logic signed [15:0] out_quat_z;

  euler_to_quaternion_unit #(.CORDIC_ITERATIONS(Iters)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_roll_angle(in_roll_angle), .in_pitch_angle(in_pitch_angle),
    .in_yaw_angle(in_yaw_angle),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_quat_w(out_quat_w), .out_quat_x(out_quat_x),
    .out_quat_y(out_quat_y), .out_quat_z(out_quat_z)
  );

  always #10 clk = ~clk;

  // Angle triples waiting to be pushed, and quaternions waiting to be popped.
  angles_t angle_queue[$];
  quat_t quat_queue[$];
  int error_count = 0;
  longint cycle_count = 0;
  bit idle_free = 1'b0;      // a stretch where neither side idles
  bit hold_sender = 1'b0;    // the sender pauses while this is set
  bit stim_done = 1'b0;

  // Arithmetic-shift floor on 64-bit signed values.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // Cosine and sine of half the angle with 20 fraction bits, via CORDIC in Q30.
  // Half angles outside +-pi/2 are folded by pi and both results negated.
  function automatic void half_trig(input logic signed [17:0] ang,
                                    output longint c, output longint s);
    longint z, x, y, dx, dy, tab[24];
    bit flip;
    tab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
            64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
            64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
            64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
            64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    z = longint'(ang) * 16384;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1'b1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1'b1;
    end
    for (int i = 0; i < (Iters > 24 ? 24 : Iters); i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= tab[i];
      end else begin
        x += dx; y -= dy; z += tab[i];
      end
    end
    c = floor_shift(x + 512, 10);
    s = floor_shift(y + 512, 10);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  // Round a sum with 60 fraction bits to Q1.15 and saturate.
  function automatic logic signed [15:0] round_sat(longint v);
    longint r;
    r = floor_shift(v + (64'sd1 <<< 44), 45);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic quat_t euler_to_quat(angles_t a);
    longint cr, sr, cp, sp, cy, sy;
    quat_t q;
    half_trig(a.roll, cr, sr);
    half_trig(a.pitch, cp, sp);
    half_trig(a.yaw, cy, sy);
    q.w = round_sat(cy * cr * cp + sy * sr * sp);
    q.x = round_sat(cy * sr * cp - sy * cr * sp);
    q.y = round_sat(cy * cr * sp + sy * sr * cp);
    q.z = round_sat(sy * cr * cp - cy * sr * sp);
    return q;
  endfunction

  function automatic logic signed [17:0] pick_angle();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 18'($urandom());               // any 18-bit code
    if (r == 1) return $urandom_range(0, 1) ? 18'sd102944 : -18'sd102944;
    return $signed(18'($urandom_range(0, 205888))) - 18'sd102944;
  endfunction

  // Snapshot of full at the rising edge, so the driver knows what was taken.
  logic in_full_s = 1'b1;
  angles_t taken;

  // Driver: at each falling edge, applies a request from the pending queue unless held or idling at random.
  // The expectation is recorded at the rising edge where the request is taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full_s) begin
        void'(angle_queue.pop_front());
      end
      if (!hold_sender && angle_queue.size() > 0 &&
          (idle_free || $urandom_range(0, 99) >= 38)) begin
        in_push <= 1'b1;
        in_roll_angle <= angle_queue[0].roll;
        in_pitch_angle <= angle_queue[0].pitch;
        in_yaw_angle <= angle_queue[0].yaw;
      end else begin
        in_push <= 1'b0;
      end
      out_pop <= idle_free || $urandom_range(0, 99) >= 38;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_full_s <= in_full;
    if (rst_n && in_push && !in_full) begin
      taken = '{roll: in_roll_angle, pitch: in_pitch_angle, yaw: in_yaw_angle};
      quat_queue.push_back(euler_to_quat(taken));
    end
  end

  // Monitor: checks each popped quaternion against the oldest expectation.
  quat_t want;
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (quat_queue.size() == 0) begin
        $error("result popped with no request outstanding");
        error_count++;
      end else begin
        want = quat_queue.pop_front();
        if (out_quat_w !== want.w) begin
          $error("quat_w expected %0d actual %0d", want.w, out_quat_w);
          error_count++;
        end
        if (out_quat_x !== want.x) begin
          $error("quat_x expected %0d actual %0d", want.x, out_quat_x);
          error_count++;
        end
        if (out_quat_y !== want.y) begin
          $error("quat_y expected %0d actual %0d", want.y, out_quat_y);
          error_count++;
        end
        if (out_quat_z !== want.z) begin
          $error("quat_z expected %0d actual %0d", want.z, out_quat_z);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus: directed corners first, then random requests.
  initial begin
    logic signed [17:0] corners[9];
    corners = '{18'sd0, 18'sd102944, -18'sd102944, 18'sd131071, -18'sd131072,
                18'sd51472, -18'sd51472, 18'sd51473, 18'sd1};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // Folding boundaries, the range limits and the full 18-bit extremes.
    for (int i = 0; i < 9; i++)
      angle_queue.push_back('{roll: corners[i], pitch: corners[(i + 3) % 9],
                              yaw: corners[(i + 6) % 9]});
    for (int i = 0; i < 9; i++)
      angle_queue.push_back('{roll: corners[i], pitch: corners[i], yaw: corners[i]});
    for (int i = 0; i < NumRandom / 2; i++)
      angle_queue.push_back('{roll: pick_angle(), pitch: pick_angle(),
                              yaw: pick_angle()});
    wait (angle_queue.size() == 0);
    // The sender holds off until the block has drained completely.
    hold_sender = 1'b1;
    wait (quat_queue.size() == 0);
    @(negedge clk);
    hold_sender = 1'b0;
    idle_free = 1'b1;
    for (int i = 0; i < 300; i++)
      angle_queue.push_back('{roll: pick_angle(), pitch: pick_angle(),
                              yaw: pick_angle()});
    wait (angle_queue.size() == 0);
    idle_free = 1'b0;
    for (int i = 0; i < NumRandom / 2 - 300; i++)
      angle_queue.push_back('{roll: pick_angle(), pitch: pick_angle(),
                              yaw: pick_angle()});
    wait (angle_queue.size() == 0);
    wait (quat_queue.size() == 0);
    repeat (Latency + 4) @(posedge clk);
    if (error_count == 0 && quat_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/e2q_pkg.sv
rtl/core/e2q_front.sv
rtl/core/e2q_back.sv
rtl/core/euler_to_quaternion_unit.sv
test/tb_top.sv
